[sv/vbf_pkg.sv]
// Package for the volume box filter: widths, register indexes and defaults.
`timescale 1ns / 1ps
package vbf_pkg;
    localparam int DEF_MAX_X = 64;
    localparam int DEF_MAX_Y = 64;
    localparam int DEF_MAX_Z = 1024;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_KIND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLANAR_ONLY = 3'd4;
    localparam logic CMD_DRAIN = 1'b1;
    localparam logic KIND_MAX = 1'b1;
    // Divider request and reply between the top level and the divider.
    typedef struct packed {
        logic        start;
        logic [13:0] num;
        logic [5:0]  den;
    } div_req_t;
    typedef struct packed {
        logic       done;
        logic [7:0] quot;
    } div_rsp_t;
endpackage

[sv/vbf_div.sv]
// Restoring divider, one quotient bit per cycle, for the rounded mean.
`timescale 1ns / 1ps
module vbf_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  vbf_pkg::div_req_t req,
    output vbf_pkg::div_rsp_t rsp
);
    import vbf_pkg::*;

    logic [12:0] rem_reg;
    logic [12:0] rem_next;
    logic [13:0] num_reg;
    logic [5:0]  den_reg;
    logic [7:0]  quot_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [13:0] trial;

    // Quotient fits 8 bits since the mean never exceeds 255.
    always_comb
    begin
        rem_next = {rem_reg[11:0], num_reg[13]};
        trial = {1'b0, rem_next} - {8'd0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                num_reg  <= req.num;
                den_reg  <= req.den;
                quot_reg <= '0;
                cnt_reg  <= 4'd14;
            end
            else if (busy_reg)
            begin
                num_reg <= {num_reg[12:0], 1'b0};
                if (!trial[13])
                begin
                    rem_reg  <= trial[12:0];
                    quot_reg <= {quot_reg[6:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_next;
                    quot_reg <= {quot_reg[6:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_idle_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> !busy_reg)
        else $error("divider still busy when done");
    a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!busy_reg && !$past(req.start)) |-> (cnt_reg == 4'd0))
        else $error("divider counter left running");
endmodule

[sv/volume_box_filter_max_avg_core.sv]
// Top level: plane ring memory, window sequencer and output register.
//
//   channel | dir | handshake            | payload
//   s_axis  | in  | s_axis_tvalid/tready | tdata = voxel, tuser = command
//   m_axis  | out | m_axis_tvalid/tready | tdata = filtered, tlast = last
//   cfg     | in  | cfg_we               | cfg_index, cfg_data
//
// A word with no result passes the idle, check and address states back to idle.
// With a result the sequencer then reads the window (one memory read per cycle),
// runs the bit-serial divider in mean mode and loads the output register.
// Reset clears counters and control; ring contents are undefined until written.
// A waiting result in the output register holds back only the next result, and input while it waits.
`timescale 1ns / 1ps
module volume_box_filter_max_avg_core
#(
    parameter int MAX_X = vbf_pkg::DEF_MAX_X,
    parameter int MAX_Y = vbf_pkg::DEF_MAX_Y,
    parameter int MAX_Z = vbf_pkg::DEF_MAX_Z
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] voxel
    input  logic                              s_axis_tuser,  // [0] command
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,  // [7:0] filtered
    output logic                              m_axis_tlast,
    input  logic                              cfg_we,
    input  logic [vbf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vbf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import vbf_pkg::*;

    localparam int XW = $clog2(MAX_X + 1);
    localparam int YW = $clog2(MAX_Y + 1);
    localparam int ZW = $clog2(MAX_Z + 1);
    localparam int XA = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int YA = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int DEPTH = 4 * (1 << XA) * (1 << YA);
    localparam int AW = 2 + XA + YA;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_ADDR, ST_READ, ST_DIV, ST_OUT
    } state_t;

    state_t state_reg;
    logic [6:0]  size_x_reg;
    logic [6:0]  size_y_reg;
    logic [10:0] size_z_reg;
    logic        kind_reg;
    logic        planar_reg;
    logic [XW-1:0] sx, ix_reg, ox_reg, cx_reg, x0, x1;
    logic [YW-1:0] sy, iy_reg, oy_reg, cy_reg, y0, y1;
    logic [ZW-1:0] sz, iz_reg, oz_reg, cz_reg, z0, z1;
    logic          in_done_reg;
    logic [12:0]   sum_reg;
    logic [5:0]    n_reg;
    logic [7:0]    mx_reg;
    logic          rd_pend_reg;
    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] wr_addr, rd_addr;
    logic          out_valid_reg;
    logic [7:0]    out_data_reg;
    logic          out_last_reg;
    logic          last_vox;
    logic          cmd_reg;
    logic [7:0]    vox_reg;
    logic          ready_win;
    div_req_t      dreq;
    div_rsp_t      drsp;

    // Clamp sizes to 1..MAX.
    always_comb
    begin
        sx = (size_x_reg == 7'd0) ? XW'(1) :
             (32'(size_x_reg) > MAX_X) ? XW'(MAX_X) : XW'(size_x_reg);
        sy = (size_y_reg == 7'd0) ? YW'(1) :
             (32'(size_y_reg) > MAX_Y) ? YW'(MAX_Y) : YW'(size_y_reg);
        sz = (size_z_reg == 11'd0) ? ZW'(1) :
             (32'(size_z_reg) > MAX_Z) ? ZW'(MAX_Z) : ZW'(size_z_reg);
        x0 = (ox_reg != '0) ? ox_reg - XW'(1) : ox_reg;
        x1 = (ox_reg + XW'(1) < sx) ? ox_reg + XW'(1) : ox_reg;
        y0 = (oy_reg != '0) ? oy_reg - YW'(1) : oy_reg;
        y1 = (oy_reg + YW'(1) < sy) ? oy_reg + YW'(1) : oy_reg;
        z0 = (planar_reg || oz_reg == '0) ? oz_reg : oz_reg - ZW'(1);
        z1 = (!planar_reg && oz_reg + ZW'(1) < sz) ? oz_reg + ZW'(1) : oz_reg;
        // Window complete when the input cursor is past (x1,y1,z1) or the volume is fully read in.
        ready_win = in_done_reg || (iz_reg > z1) ||
                    (iz_reg == z1 && (iy_reg > y1 || (iy_reg == y1 && ix_reg > x1)));
        last_vox = (ox_reg == sx - XW'(1)) && (oy_reg == sy - YW'(1)) &&
                   (oz_reg == sz - ZW'(1));
        wr_addr = {iz_reg[1:0], iy_reg[YA-1:0], ix_reg[XA-1:0]};
        rd_addr = {cz_reg[1:0], cy_reg[YA-1:0], cx_reg[XA-1:0]};
        dreq.start = (state_reg == ST_READ) && !rd_pend_reg && !kind_reg &&
                     (cz_reg > z1);
        dreq.num = {sum_reg, 1'b0} + 14'(n_reg);
        dreq.den = {n_reg[4:0], 1'b0};
    end

    vbf_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CHECK && cmd_reg != CMD_DRAIN && !in_done_reg)
            mem[wr_addr] <= vox_reg;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            size_x_reg <= 7'd64; size_y_reg <= 7'd64; size_z_reg <= 11'd64;
            kind_reg <= 1'b0; planar_reg <= 1'b0;
            ix_reg <= '0; iy_reg <= '0; iz_reg <= '0; in_done_reg <= 1'b0;
            ox_reg <= '0; oy_reg <= '0; oz_reg <= '0;
            out_valid_reg <= 1'b0; out_last_reg <= 1'b0; rd_pend_reg <= 1'b0;
        end
        else
        begin
            if (m_axis_tready && state_reg != ST_OUT)
                out_valid_reg <= 1'b0;
            if (cfg_we && cfg_index <= REG_PLANAR_ONLY)
            begin
                unique case (cfg_index)
                    REG_SIZE_X:      size_x_reg <= cfg_data[6:0];
                    REG_SIZE_Y:      size_y_reg <= cfg_data[6:0];
                    REG_SIZE_Z:      size_z_reg <= cfg_data;
                    REG_FILTER_KIND: kind_reg   <= cfg_data[0];
                    default:         planar_reg <= cfg_data[0];
                endcase
                ix_reg <= '0; iy_reg <= '0; iz_reg <= '0; in_done_reg <= 1'b0;
                ox_reg <= '0; oy_reg <= '0; oz_reg <= '0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        cmd_reg <= s_axis_tuser;
                        vox_reg <= s_axis_tdata;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (cmd_reg != CMD_DRAIN && !in_done_reg)
                    begin
                        if (ix_reg + XW'(1) < sx)
                            ix_reg <= ix_reg + XW'(1);
                        else
                        begin
                            ix_reg <= '0;
                            if (iy_reg + YW'(1) < sy)
                                iy_reg <= iy_reg + YW'(1);
                            else
                            begin
                                iy_reg <= '0;
                                if (iz_reg + ZW'(1) < sz)
                                    iz_reg <= iz_reg + ZW'(1);
                                else
                                    in_done_reg <= 1'b1;
                            end
                        end
                    end
                    state_reg <= ST_ADDR;
                end
                ST_ADDR:
                begin
                    if (ready_win)
                    begin
                        cx_reg <= x0; cy_reg <= y0; cz_reg <= z0;
                        sum_reg <= '0; n_reg <= '0; mx_reg <= '0;
                        rd_pend_reg <= 1'b0;
                        state_reg <= ST_READ;
                    end
                    else
                        state_reg <= ST_IDLE;
                end
                ST_READ:
                begin
                    if (rd_pend_reg)
                    begin
                        sum_reg <= sum_reg + 13'(rd_data_reg);
                        n_reg <= n_reg + 6'd1;
                        if (rd_data_reg > mx_reg)
                            mx_reg <= rd_data_reg;
                    end
                    if (cz_reg > z1)
                    begin
                        if (!rd_pend_reg)
                            state_reg <= kind_reg ? ST_OUT : ST_DIV;
                        rd_pend_reg <= 1'b0;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b1;
                        if (cx_reg < x1)
                            cx_reg <= cx_reg + XW'(1);
                        else
                        begin
                            cx_reg <= x0;
                            if (cy_reg < y1)
                                cy_reg <= cy_reg + YW'(1);
                            else
                            begin
                                cy_reg <= y0;
                                cz_reg <= cz_reg + ZW'(1);
                            end
                        end
                    end
                end
                ST_DIV:
                begin
                    if (drsp.done)
                    begin
                        mx_reg <= drsp.quot;
                        state_reg <= ST_OUT;
                    end
                end
                default:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg <= mx_reg;
                        out_last_reg <= last_vox;
                        state_reg <= ST_IDLE;
                        if (last_vox)
                        begin
                            ix_reg <= '0; iy_reg <= '0; iz_reg <= '0;
                            in_done_reg <= 1'b0;
                            ox_reg <= '0; oy_reg <= '0; oz_reg <= '0;
                        end
                        else if (ox_reg + XW'(1) < sx)
                            ox_reg <= ox_reg + XW'(1);
                        else
                        begin
                            ox_reg <= '0;
                            if (oy_reg + YW'(1) < sy)
                                oy_reg <= oy_reg + YW'(1);
                            else
                            begin
                                oy_reg <= '0;
                                oz_reg <= oz_reg + ZW'(1);
                            end
                        end
                    end
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == ST_IDLE))
        else $error("ready outside idle");
    a_out_counter_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ox_reg < sx || cfg_we || $past(cfg_we)) || state_reg == ST_IDLE)
        else $error("output column out of range");
    a_div_start_mean: assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |-> !kind_reg)
        else $error("divider started in max mode");
endmodule

[tb/volume_box_filter_max_avg_core_tb.sv]
// Testbench for the volume box filter: streamed volumes checked against a predictor.
`timescale 1ns / 1ps
module volume_box_filter_max_avg_core_tb;
    import vbf_pkg::*;

    localparam int RING_WORDS = 4 * DEF_MAX_X * DEF_MAX_Y;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic       drain;
        logic [7:0] voxel;
    } voxel_word_t;

    typedef struct packed {
        logic [7:0] filtered;
        logic       last;
    } filter_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    volume_box_filter_max_avg_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    voxel_word_t pending_words[$];
    filter_out_t expected_voxels[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int cycles = 0;

    // Predictor state.
    logic [7:0] ring_mem[RING_WORDS];
    int voxels_in;
    int voxels_out;
    logic [6:0] reg_sx = 7'd64;
    logic [6:0] reg_sy = 7'd64;
    logic [10:0] reg_sz = 11'd64;
    logic reg_kind = 1'b0;
    logic reg_planar = 1'b0;

    function automatic int clip_size(int v, int hi);
        if (v < 1)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic int ring_index(int x, int y, int z);
        return ((z % 4) * DEF_MAX_Y + y) * DEF_MAX_X + x;
    endfunction

    task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_SIZE_X: reg_sx = val[6:0];
            REG_SIZE_Y: reg_sy = val[6:0];
            REG_SIZE_Z: reg_sz = val;
            REG_FILTER_KIND: reg_kind = val[0];
            REG_PLANAR_ONLY: reg_planar = val[0];
            default: return;
        endcase
        voxels_in = 0;
        voxels_out = 0;
    endtask

    task automatic filter_voxel(voxel_word_t w);
        int sx, sy, sz, plane, total, x, y, z;
        int x0, x1, y0, y1, z0, z1, sum, n, mx, v;
        filter_out_t r;
        sx = clip_size(reg_sx, DEF_MAX_X);
        sy = clip_size(reg_sy, DEF_MAX_Y);
        sz = clip_size(reg_sz, DEF_MAX_Z);
        plane = sx * sy;
        total = plane * sz;
        if (w.drain != CMD_DRAIN && voxels_in < total)
        begin
            ring_mem[ring_index(voxels_in % sx, (voxels_in / sx) % sy, voxels_in / plane)]
                = w.voxel;
            voxels_in++;
        end
        if (voxels_out >= total)
            return;
        x = voxels_out % sx;
        y = (voxels_out / sx) % sy;
        z = voxels_out / plane;
        x0 = (x > 0) ? x - 1 : x;
        x1 = (x + 1 < sx) ? x + 1 : x;
        y0 = (y > 0) ? y - 1 : y;
        y1 = (y + 1 < sy) ? y + 1 : y;
        z0 = z;
        z1 = z;
        if (!reg_planar)
        begin
            z0 = (z > 0) ? z - 1 : z;
            z1 = (z + 1 < sz) ? z + 1 : z;
        end
        if (voxels_in <= (z1 * sy + y1) * sx + x1)
            return;
        sum = 0;
        n = 0;
        mx = 0;
        for (int cz = z0; cz <= z1; cz++)
            for (int cy = y0; cy <= y1; cy++)
                for (int cx = x0; cx <= x1; cx++)
                begin
                    v = ring_mem[ring_index(cx, cy, cz)];
                    sum += v;
                    n++;
                    if (v > mx)
                        mx = v;
                end
        r.filtered = (reg_kind == KIND_MAX) ? mx[7:0] : 8'((2 * sum + n) / (2 * n));
        voxels_out++;
        r.last = (voxels_out == total);
        if (r.last)
        begin
            voxels_in = 0;
            voxels_out = 0;
        end
        expected_voxels.push_back(r);
    endtask

    // Sender: a new word is offered only when the current one is taken or none is up.
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            filter_voxel('{drain: s_axis_tuser, voxel: s_axis_tdata});
        if (!s_axis_tvalid || s_axis_tready)
        begin
            if (rst_n && pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                voxel_word_t w;
                w = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= w.drain;
                s_axis_tdata <= w.voxel;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver and checker.
    always @(posedge clk)
    begin
        m_axis_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_voxels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: filtered %0d last %0b",
                             m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                filter_out_t e;
                e = expected_voxels.pop_front();
                if (e.filtered !== m_axis_tdata || e.last !== m_axis_tlast)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0b, got %0d/%0b",
                                 e.filtered, e.last, m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        apply_register(idx, val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_words.size() > 0 || s_axis_tvalid || expected_voxels.size() > 0)
            @(posedge clk);
        // Drain ticks that produce nothing may still be in flight.
        repeat (60) @(posedge clk);
    endtask

    // pattern: 0 random, 1 all zero, 2 all 255, 3 alternating extremes.
    task automatic stream_volume(int sx, int sy, int sz, int kind, int planar,
                                 int pattern, bit early, bit surplus, bit pause_mid);
        int total, lag, csx, csy, csz;
        logic [7:0] v;
        write_register(REG_SIZE_X, CFG_DATA_W'(sx));
        write_register(REG_SIZE_Y, CFG_DATA_W'(sy));
        write_register(REG_SIZE_Z, CFG_DATA_W'(sz));
        write_register(REG_FILTER_KIND, CFG_DATA_W'(kind));
        write_register(REG_PLANAR_ONLY, CFG_DATA_W'(planar));
        csx = clip_size(sx, DEF_MAX_X);
        csy = clip_size(sy, DEF_MAX_Y);
        csz = clip_size(sz, DEF_MAX_Z);
        total = csx * csy * csz;
        // Results trail the input by at most one plane, one row and one voxel, or one row and one voxel in 2D.
        lag = (planar != 0 || csz == 1) ? csx + 2 : csx * csy + csx + 2;
        if (early)
            pending_words.push_back('{drain: CMD_DRAIN, voxel: 8'($urandom)});
        for (int i = 0; i < total; i++)
        begin
            case (pattern)
                1: v = 8'd0;
                2: v = 8'd255;
                3: v = i[0] ? 8'd255 : 8'd0;
                default: v = 8'($urandom);
            endcase
            pending_words.push_back('{drain: ~CMD_DRAIN, voxel: v});
            // Let everything settle halfway through, then carry on.
            if (pause_mid && i == total / 2)
                wait_drained();
            if (early && $urandom_range(9) == 0)
                pending_words.push_back('{drain: CMD_DRAIN, voxel: 8'($urandom)});
        end
        if (surplus)
            repeat (2) pending_words.push_back('{drain: ~CMD_DRAIN, voxel: 8'($urandom)});
        repeat (lag) pending_words.push_back('{drain: CMD_DRAIN, voxel: 8'($urandom)});
        wait_drained();
    endtask

    initial
    begin
        int data_sent;
        int sx, sy, sz;
        voxels_in = 0;
        voxels_out = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed volumes: extremes of the voxel range, both kinds, planar, clamps.
        stream_volume(1, 1, 1, 0, 0, 2, 1'b1, 1'b1, 1'b0);
        stream_volume(0, 0, 0, 1, 0, 1, 1'b0, 1'b0, 1'b0);
        stream_volume(3, 2, 2, 0, 0, 3, 1'b1, 1'b1, 1'b0);
        stream_volume(2, 2, 3, 1, 1, 3, 1'b0, 1'b0, 1'b0);
        write_register(REG_SIZE_Z, 11'd2047);
        stream_volume(127, 1, 1, 0, 1, 0, 1'b0, 1'b0, 1'b0);
        stream_volume(1, 127, 1, 1, 0, 0, 1'b0, 1'b1, 1'b0);
        write_register(REG_UNUSED, 11'h555);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            data_sent = 0;
            while (data_sent < 30)
            begin
                sx = $urandom_range(6, 1);
                sy = $urandom_range(5, 1);
                sz = $urandom_range(4, 1);
                stream_volume(sx, sy, sz, $urandom_range(1), $urandom_range(1), 0,
                              $urandom_range(3) == 0, $urandom_range(3) == 0,
                              phase == 3 && data_sent == 0);
                data_sent += sx * sy * sz;
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
